/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes of the sorted priority queue
// Word formats of both channels, operation and status codes and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // default number of entries
  localparam int DEPTH_DFLT = 16;

  // field widths fixed by the word formats
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_OVER  = 2'd1;
  localparam status_t ST_UNDER = 2'd2;

  typedef logic [OCC_W-1:0] occ_t;

  // input word
  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] item_data;
    logic signed [DATA_W-1:0] item_priority;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] out_data;
    logic signed [DATA_W-1:0] out_priority;
    occ_t                     occupancy;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;  // capture the accepted word
    logic exec;     // run the operation and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue - bounded sorted priority queue
// Keeps up to DEPTH entries ordered by signed priority, smaller first, equal
// priorities in arrival order. Insert and delete each give one result word.
//
//   channel  ports                          word
//   in       in_valid  in_stall  in_word    op, item_data, item_priority
//   out      out_valid out_stall out_word   status, out_data, out_priority,
//                                           occupancy
//
// each word is first captured, then goes through the parallel
// compare-and-shift across the entry row that also loads the result register
// a new word is taken while the previous result still waits under out_stall;
// the operation step then waits for the result register to free up
// synchronous active-low reset empties the queue, entry contents are not
// cleared, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spq_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spq_pkg::out_word_t      out_word
);

  spq_pkg::dp_cmd_t cmd;

  // sequencer
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // entry row and word registers
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // an executed operation always presents a result next cycle
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed operation did not present a result");

  // capture and execute never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_in && cmd.exec))
    else $error("capture and execute in the same cycle");

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a word is in work");

  // an underflow leaves the queue empty
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == spq_pkg::ST_UNDER) |-> (out_word.occupancy == '0))
    else $error("underflow reported with entries held");

endmodule

`default_nettype wire

/* hw/rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl - sequencer of the sorted priority queue
// Takes one word at a time, runs it through the datapath once the result
// register is free and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output spq_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new word this cycle
  assign out_free = !out_valid_r || !out_stall;

  // commands and next state
  always_comb begin
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    priority if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hw/rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath - sorted entry row of the priority queue
// Row of entry cells kept in priority order. On insert every cell compares
// its priority with the new one at once and holds, shifts back or loads;
// on delete the row shifts forward. Also holds the input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::dp_cmd_t   cmd,
  input  wire spq_pkg::in_word_t  in_word,
  output spq_pkg::out_word_t      out_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  spq_pkg::in_word_t  in_r;
  spq_pkg::out_word_t out_r, out_nxt;

  logic signed [spq_pkg::DATA_W-1:0] pay_r  [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] rank_r [DEPTH];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty, do_ins, do_del;
  logic [DEPTH-1:0] gt;

  // captured input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_word;
    end
  end

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_ins = cmd.exec && (in_r.op == spq_pkg::OP_INSERT) && !full;
  assign do_del = cmd.exec && (in_r.op == spq_pkg::OP_DELETE) && !empty;

  // per-cell compare: held entry ranks strictly behind the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < cnt_r) && (rank_r[i] > in_r.item_priority);
    end
  end

  // entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              prev_gt;
    logic                              at_end;
    logic signed [spq_pkg::DATA_W-1:0] up_pay, up_rank;
    logic signed [spq_pkg::DATA_W-1:0] dn_pay, dn_rank;

    if (i == 0) begin : g_first
      assign prev_gt = 1'b0;
      assign up_pay  = pay_r[i];
      assign up_rank = rank_r[i];
    end else begin : g_rest
      assign prev_gt = gt[i-1];
      assign up_pay  = pay_r[i-1];
      assign up_rank = rank_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_pay  = pay_r[i];
      assign dn_rank = rank_r[i];
    end else begin : g_inner
      assign dn_pay  = pay_r[i+1];
      assign dn_rank = rank_r[i+1];
    end

    assign at_end = (cnt_r == CNT_W'(i));

    always_ff @(posedge clk) begin
      priority if (do_ins && prev_gt) begin
        pay_r[i]  <= up_pay;
        rank_r[i] <= up_rank;
      end else if (do_ins && (gt[i] || at_end)) begin
        pay_r[i]  <= in_r.item_data;
        rank_r[i] <= in_r.item_priority;
      end else if (do_del) begin
        pay_r[i]  <= dn_pay;
        rank_r[i] <= dn_rank;
      end
    end
  end

  // entry count
  always_comb begin
    priority if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result word
  always_comb begin
    out_nxt.status       = spq_pkg::ST_DONE;
    out_nxt.out_data     = '0;
    out_nxt.out_priority = '0;
    out_nxt.occupancy    = spq_pkg::occ_t'(cnt_nxt);
    priority if (in_r.op == spq_pkg::OP_INSERT && full) begin
      out_nxt.status = spq_pkg::ST_OVER;
    end else if (in_r.op == spq_pkg::OP_DELETE && empty) begin
      out_nxt.status = spq_pkg::ST_UNDER;
    end else if (in_r.op == spq_pkg::OP_DELETE) begin
      out_nxt.out_data     = pay_r[0];
      out_nxt.out_priority = rank_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_array_priority_queue
// Sends insert and delete words through the input channel and checks every
// result word against a sorted-array model of the queue kept in the bench.
// A short directed run covers both empty and full states, the end values of
// priority and payload, and equal priorities. Random runs follow that swing
// the queue between full and empty. Bursty input and a changing stall
// pattern on the result side exercise the handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int DEPTH      = spq_pkg::DEPTH_DFLT;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  spq_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spq_pkg::out_word_t out_word;

  // words waiting to be sent and results still owed by the block
  spq_pkg::in_word_t  pending_words[$];
  spq_pkg::out_word_t expected_results[$];

  // queue model state
  logic signed [spq_pkg::DATA_W-1:0] model_payload [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] model_rank [DEPTH];
  int                                model_count = 0;

  int mismatch_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;
  int stall_tick = 0;
  int idle_cycles = 0;

  sorted_array_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // apply one operation to the model and return the result it owes
  function automatic spq_pkg::out_word_t update_queue_model(input spq_pkg::in_word_t w);
    spq_pkg::out_word_t r;
    int                 slot;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (w.op == spq_pkg::OP_INSERT) begin
      if (model_count >= DEPTH) begin
        r.status = spq_pkg::ST_OVER;
      end else begin
        slot = model_count;
        while (slot > 0 && model_rank[slot-1] > w.item_priority) begin
          model_payload[slot] = model_payload[slot-1];
          model_rank[slot]    = model_rank[slot-1];
          slot--;
        end
        model_payload[slot] = w.item_data;
        model_rank[slot]    = w.item_priority;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.status = spq_pkg::ST_UNDER;
      end else begin
        r.out_data     = model_payload[0];
        r.out_priority = model_rank[0];
        for (int k = 0; k + 1 < model_count; k++) begin
          model_payload[k] = model_payload[k+1];
          model_rank[k]    = model_rank[k+1];
        end
        model_count--;
      end
    end
    r.occupancy = spq_pkg::occ_t'(model_count);
    return r;
  endfunction

  task automatic queue_insert(input logic [spq_pkg::DATA_W-1:0] data,
                              input logic [spq_pkg::DATA_W-1:0] prio);
    spq_pkg::in_word_t w;
    w.op            = spq_pkg::OP_INSERT;
    w.item_data     = data;
    w.item_priority = prio;
    pending_words.push_back(w);
  endtask

  // payload and priority are don't-care on delete, so send noise there
  task automatic queue_delete();
    spq_pkg::in_word_t w;
    w.op            = spq_pkg::OP_DELETE;
    w.item_data     = $urandom;
    w.item_priority = $urandom;
    pending_words.push_back(w);
  endtask

  // mostly small values for ties, some full range, some end values
  function automatic logic [spq_pkg::DATA_W-1:0] pick_priority();
    logic [spq_pkg::DATA_W-1:0] p;
    case ($urandom_range(0, 3))
      0, 1: p = $urandom_range(0, 8) - 4;
      2:    p = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       p = 32'h8000_0000;
          1:       p = 32'h7FFF_FFFF;
          2:       p = 32'hFFFF_FFFF;
          default: p = 32'h0000_0000;
        endcase
      end
    endcase
    return p;
  endfunction

  // reset, stimulus and end of run
  initial begin
    logic [spq_pkg::DATA_W-1:0] dir_prio [16];
    int                         insert_weight;
    dir_prio = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'd1, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'd5, -32'sd5, 32'd100,
                 -32'sd100, 32'd3, 32'd3, 32'd2};

    // underflow on an empty queue
    queue_delete();
    // fill to the top with end values and ties, then overflow
    queue_insert(32'h7FFF_FFFF, dir_prio[0]);
    queue_insert(32'h8000_0000, dir_prio[1]);
    queue_insert(32'h0000_0000, dir_prio[2]);
    queue_insert(32'hFFFF_FFFF, dir_prio[3]);
    for (int i = 4; i < 16; i++) queue_insert(32'h1000 + i, dir_prio[i]);
    queue_insert($urandom, $urandom);
    // partial drain, ties must come out in arrival order
    repeat (5) queue_delete();

    // random runs, alternately filling and draining
    for (int seg = 0; seg < 8; seg++) begin
      insert_weight = (seg % 3 == 0) ? 3 : ((seg % 3 == 1) ? 1 : 2);
      repeat (100) begin
        if ($urandom_range(0, 3) < insert_weight) queue_insert($urandom, pick_priority());
        else queue_delete();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** sorted_array_priority_queue: PASSED **");
    end else begin
      $display("** sorted_array_priority_queue: FAILED **");
    end
    $finish;
  end

  // input driver, bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, the pattern is redrawn at the end of each random-length phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_phase_left == 0) begin
        stall_mode       <= $urandom_range(0, 3);
        stall_phase_left <= $urandom_range(8, 60);
      end else begin
        stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // monitor, predicts on each accepted input word and checks each result word
  always @(posedge clk) begin
    spq_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(update_queue_model(in_word));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected: status %0d occupancy %0d",
                 out_word.status, out_word.occupancy);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_word.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_word.status);
            mismatch_count++;
          end
          if (out_word.out_data !== want.out_data) begin
            $error("out_data expected %0d got %0d", want.out_data, out_word.out_data);
            mismatch_count++;
          end
          if (out_word.out_priority !== want.out_priority) begin
            $error("out_priority expected %0d got %0d", want.out_priority,
                   out_word.out_priority);
            mismatch_count++;
          end
          if (out_word.occupancy !== want.occupancy) begin
            $error("occupancy expected %0d got %0d", want.occupancy, out_word.occupancy);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** sorted_array_priority_queue: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

/* sorted_array_priority_queue.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_array_priority_queue.sv
sim/tb.sv
